### sv/cprl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cprl_pkg;

	// Field widths of the pixel stream and the per-column record.
	localparam int MAX_COLUMNS = 256;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ROW_W       = 8;
	localparam int PIX_W       = 8;
	localparam int SUM_W       = 15;
	localparam int CNT_W       = 9;
	localparam int HEIGHT_W    = 9;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 9'd130;

	// Divider layout: a few restoring steps per pipeline stage.
	localparam int DIV_STEPS  = 3;
	localparam int DIV_STAGES = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DQ_W       = DIV_STAGES * DIV_STEPS;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [ROW_W-1:0] row_index;
		logic [COL_W-1:0] col_index;
	} pix_beat_t;

	typedef struct packed {
		logic [COL_W-1:0] out_column;
		logic [ROW_W-1:0] center_row;
	} center_beat_t;

	// One column record as it is kept in the column memory.
	typedef struct packed {
		logic [PIX_W-1:0] peak;
		logic [SUM_W-1:0] row_sum;
		logic [CNT_W-1:0] hit_count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [SUM_W-1:0] row_sum;
		logic [CNT_W-1:0] hit_count;
	} div_req_t;

	// Working state of one divider stage; dq shifts the dividend out and
	// the quotient in.
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic             zero;
		logic [CNT_W-1:0] divisor;
		logic [CNT_W-1:0] rem;
		logic [DQ_W-1:0]  dq;
	} div_stage_t;

	// One restoring division step.
	function automatic div_stage_t div_step(input div_stage_t s);
		logic [CNT_W:0] trial;
		logic [CNT_W:0] dvs;
		logic           ge;
		div_stage_t     r;
		trial = {s.rem, s.dq[DQ_W-1]};
		dvs   = {1'b0, s.divisor};
		ge    = (trial >= dvs);
		r     = s;
		if (ge) begin
			r.rem = CNT_W'(trial - dvs);
		end else begin
			r.rem = trial[CNT_W-1:0];
		end
		r.dq = {s.dq[DQ_W-2:0], ge};
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/cprl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cprl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### sv/cprl_div.sv
`timescale 1ns / 1ps
`default_nettype none

module cprl_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire cprl_pkg::div_req_t      in_req,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output cprl_pkg::center_beat_t       out_data
);

	import cprl_pkg::*;

	logic [DIV_STAGES-1:0] vld_q;
	div_stage_t            pipe_q [DIV_STAGES];
	logic [DIV_STAGES:0]   rdy_chain;
	logic [DIV_STAGES-1:0] src_vld;
	div_stage_t            src    [DIV_STAGES];
	div_stage_t            nxt    [DIV_STAGES];
	div_stage_t            head;

	// Elastic stall chain: a stage takes a new beat when empty or draining.
	always_comb begin
		rdy_chain[DIV_STAGES] = out_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			rdy_chain[k] = !vld_q[k] || rdy_chain[k+1];
		end
	end

	assign in_ready = rdy_chain[0];
	assign src_vld  = {vld_q[DIV_STAGES-2:0], in_valid};

	// Seed the first stage from the request.
	always_comb begin
		head.column  = in_req.column;
		head.zero    = (in_req.hit_count == '0);
		head.divisor = in_req.hit_count;
		head.rem     = '0;
		head.dq      = DQ_W'(in_req.row_sum);
	end

	// Each stage runs a few restoring steps on the beat it receives.
	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			src[k] = (k == 0) ? head : pipe_q[(k == 0) ? 0 : k - 1];
			nxt[k] = src[k];
			for (int j = 0; j < DIV_STEPS; j++) begin
				nxt[k] = div_step(nxt[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				if (rdy_chain[k]) begin
					vld_q[k] <= src_vld[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (rdy_chain[k] && src_vld[k]) begin
				pipe_q[k] <= nxt[k];
			end
		end
	end

	// The last stage doubles as the output register.
	assign out_valid           = vld_q[DIV_STAGES-1];
	assign out_data.out_column = pipe_q[DIV_STAGES-1].column;
	assign out_data.center_row = pipe_q[DIV_STAGES-1].zero ? '0
		: pipe_q[DIV_STAGES-1].dq[ROW_W-1:0];

endmodule

`default_nettype wire

### sv/column_peak_row_locator.sv
// Path: a pixel beat that closes a column passes the column memory read at acceptance and the
// update in stage 1, then four divider stages; the fifth divider stage is the output register.
// Output stalls hold the beat in the divider.
// Throughput: one pixel beat per cycle unless a closing beat waits for the divider; set by the
// column memory read-modify-write loop, which a one-entry forwarding register keeps closed.
// Reset: clears all valid flags and sets height_q to 130; the column memory is not cleared,
// every column record is started afresh by its row 0 pixel.
`timescale 1ns / 1ps
`default_nettype none

module column_peak_row_locator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire cprl_pkg::pix_beat_t            in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output cprl_pkg::center_beat_t              out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [cprl_pkg::HEIGHT_W-1:0]  cfg_data
);

	import cprl_pkg::*;

	logic [HEIGHT_W-1:0] height_q;
	logic                vld_s1;
	pix_beat_t           pix_s1;
	logic                fwd_vld_q;
	logic [COL_W-1:0]    fwd_col_q;
	entry_t              fwd_entry_q;
	logic [ENTRY_W-1:0]  rd_raw;
	entry_t              rd_entry;
	entry_t              old_entry;
	entry_t              upd_entry;
	logic                accept;
	logic                emit_s1;
	logic                s1_go;
	logic                div_in_ready;
	logic                div_req_vld;
	div_req_t            div_req;

	// Configuration register, always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			height_q <= cfg_data;
		end
	end

	// Stage 1 retires when it closes no column or the divider takes it.
	assign s1_go    = vld_s1 && (!emit_s1 || div_in_ready);
	assign in_ready = !vld_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= in_data;
		end
	end

	// Column memory: read at acceptance, written back when stage 1 retires.
	cprl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_COLUMNS)
	) u_col_ram (
		.clk     (clk),
		.wr_en   (s1_go),
		.wr_addr (pix_s1.col_index),
		.wr_data (upd_entry),
		.rd_en   (accept),
		.rd_addr (in_data.col_index),
		.rd_data (rd_raw)
	);

	assign rd_entry = entry_t'(rd_raw);

	// The write of the previous beat lands at the edge this beat is read;
	// forward it when the columns match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (s1_go) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			fwd_col_q   <= pix_s1.col_index;
			fwd_entry_q <= upd_entry;
		end
	end

	// Peak tracking update for the column record.
	always_comb begin
		old_entry = (fwd_vld_q && fwd_col_q == pix_s1.col_index) ? fwd_entry_q : rd_entry;
		upd_entry = old_entry;
		if (pix_s1.row_index == '0) begin
			upd_entry.peak      = pix_s1.pixel;
			upd_entry.row_sum   = '0;
			upd_entry.hit_count = CNT_W'(1);
		end else if (pix_s1.pixel > old_entry.peak) begin
			upd_entry.peak      = pix_s1.pixel;
			upd_entry.row_sum   = SUM_W'(pix_s1.row_index);
			upd_entry.hit_count = CNT_W'(1);
		end else if (pix_s1.pixel == old_entry.peak) begin
			upd_entry.row_sum   = old_entry.row_sum + SUM_W'(pix_s1.row_index);
			upd_entry.hit_count = old_entry.hit_count + CNT_W'(1);
		end
	end

	// The last row of the region closes the column.
	assign emit_s1 = (height_q != '0)
		&& (HEIGHT_W'(pix_s1.row_index) == height_q - HEIGHT_W'(1));

	assign div_req_vld       = vld_s1 && emit_s1;
	assign div_req.column    = pix_s1.col_index;
	assign div_req.row_sum   = upd_entry.row_sum;
	assign div_req.hit_count = upd_entry.hit_count;

	cprl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_req_vld),
		.in_ready  (div_in_ready),
		.in_req    (div_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// An accepted beat always lands in stage 1.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_s1)
		else $error("accepted beat missing from stage 1");

	// A stalled stage 1 keeps its beat.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s1_go |=> vld_s1 && $stable(pix_s1))
		else $error("stage 1 beat lost during stall");

	// The forwarding register tracks the last written column.
	a_fwd_track: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |=> fwd_vld_q && fwd_col_q == $past(pix_s1.col_index))
		else $error("forwarding register out of step with write");

	// A zero height never closes a column.
	a_no_close: assert property (@(posedge clk) disable iff (!arst_n)
		height_q == '0 |-> !div_req_vld)
		else $error("column closed with zero height");

endmodule

`default_nettype wire
